### design/pdt_pkg.sv
package pdt_pkg;

  // defaults for the top level parameters
  localparam int NUM_SLOTS_DEF    = 16;
  localparam int TIME_WIDTH_DEF   = 32;
  localparam int HANDLE_WIDTH_DEF = 16;

  // fixed field widths on the stream ports
  localparam int OPCODE_W  = 3;
  localparam int ID_W      = 4;
  localparam int HANDLE_PW = 16;
  localparam int TIME_PW   = 32;
  localparam int STATUS_W  = 3;
  localparam int SLOT_PW   = 4;

  localparam int IN_FIELDS_W  = ID_W + HANDLE_PW + TIME_PW;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SLOT_PW + HANDLE_PW + TIME_PW;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD_PERIODIC = 3'd0,
    OP_ADD_AT       = 3'd1,
    OP_DELETE       = 3'd2,
    OP_CHANGE       = 3'd3,
    OP_TICK         = 3'd4,
    OP_SCAN         = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DISPATCH  = 3'd3,
    ST_NONE_DUE  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FIND,
    S_SCAN,
    S_CMP,
    S_DONE
  } state_t;

  // write enables of the slot memory
  typedef struct packed {
    logic handle;
    logic period;
    logic next_run;
  } slot_we_t;

endpackage

### design/pdt_slot_ram.sv
module pdt_slot_ram import pdt_pkg::*; #(
  parameter int NUM_SLOTS    = NUM_SLOTS_DEF,
  parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
  parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF,
  parameter int IDX_W        = $clog2(NUM_SLOTS)
) (
  input  logic                    clk,
  input  slot_we_t                we,
  input  logic [IDX_W-1:0]        wr_addr,
  input  logic [HANDLE_WIDTH-1:0] wr_handle,
  input  logic [TIME_WIDTH-1:0]   wr_period,
  input  logic [TIME_WIDTH-1:0]   wr_next,
  input  logic [IDX_W-1:0]        rd_addr,
  output logic [HANDLE_WIDTH-1:0] rd_handle,
  output logic [TIME_WIDTH-1:0]   rd_period,
  output logic [TIME_WIDTH-1:0]   rd_next
);

  logic [HANDLE_WIDTH-1:0] handle_mem [NUM_SLOTS];
  logic [TIME_WIDTH-1:0]   period_mem [NUM_SLOTS];
  logic [TIME_WIDTH-1:0]   next_mem   [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (we.handle) begin
      handle_mem[wr_addr] <= wr_handle;
    end
    if (we.period) begin
      period_mem[wr_addr] <= wr_period;
    end
    if (we.next_run) begin
      next_mem[wr_addr] <= wr_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_handle <= handle_mem[rd_addr];
    rd_period <= period_mem[rd_addr];
    rd_next   <= next_mem[rd_addr];
  end

endmodule

### design/periodic_task_dispatch_table.sv
// work starts the cycle after the accept; the result is valid the cycle after the last work cycle
// add: walks up from slot 0 to the lowest free slot; answers full after the last slot
// delete, change period, tick: handled in the execute state
// scan: walks all slots through the slot memory, comparing each occupied one, then a done state
// ready again the cycle after the last work cycle; a stalled result holds the block in its work state
// reset clears tick counter and occupancy flags; slot memory needs no clearing
module periodic_task_dispatch_table import pdt_pkg::*; #(
  parameter int NUM_SLOTS    = NUM_SLOTS_DEF,
  parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
  parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // task_id, task_handle, time_value, pad
  input  logic [OPCODE_W-1:0]   s_axis_tuser,  // opcode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // slot, handle_out, time_now, pad
  output logic [STATUS_W-1:0]   m_axis_tuser,  // status
  output logic                  m_axis_tlast
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  state_t state, state_next;

  logic [IDX_W-1:0]        idx;
  logic [OPCODE_W-1:0]     op;
  logic [ID_W-1:0]         op_id;
  logic [HANDLE_WIDTH-1:0] op_handle;
  logic [TIME_WIDTH-1:0]   op_time;
  logic [TIME_WIDTH-1:0]   tick;
  logic [NUM_SLOTS-1:0]    occ;

  logic                    pend_valid;
  logic [IDX_W-1:0]        pend_slot;
  logic [HANDLE_WIDTH-1:0] pend_handle;

  logic                    out_valid;
  status_t                 out_status;
  logic [SLOT_PW-1:0]      out_slot;
  logic [HANDLE_PW-1:0]    out_handle;
  logic [TIME_PW-1:0]      out_time;
  logic                    out_last;

  // memory side
  slot_we_t                we;
  logic [IDX_W-1:0]        wr_addr;
  logic [TIME_WIDTH-1:0]   wr_period;
  logic [TIME_WIDTH-1:0]   wr_next;
  logic [HANDLE_WIDTH-1:0] rd_handle;
  logic [TIME_WIDTH-1:0]   rd_period;
  logic [TIME_WIDTH-1:0]   rd_next;

  // control from the sequencer
  logic                    emit;
  status_t                 e_status;
  logic [IDX_W-1:0]        e_slot;
  logic [HANDLE_WIDTH-1:0] e_handle;
  logic                    e_last;
  logic                    occ_wr;
  logic [IDX_W-1:0]        occ_addr;
  logic                    occ_val;
  logic                    tick_inc;
  logic                    idx_inc;
  logic                    pend_load;

  // width adaptation between ports and storage
  logic [HANDLE_WIDTH+HANDLE_PW-1:0] hin_ext;
  logic [TIME_WIDTH+TIME_PW-1:0]     tin_ext;
  logic [HANDLE_WIDTH+HANDLE_PW-1:0] hout_ext;
  logic [TIME_WIDTH+TIME_PW-1:0]     tout_ext;
  logic [IDX_W+SLOT_PW-1:0]          slot_ext;
  logic [IDX_W+ID_W-1:0]             id_ext;
  logic [IDX_W-1:0]                  id_idx;
  logic [TIME_WIDTH-1:0]             tick_after;

  logic accept;
  logic out_free;
  logic id_found;
  logic due;
  logic at_last;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;
  assign at_last  = (idx == LAST_IDX);

  assign hin_ext = (HANDLE_WIDTH + HANDLE_PW)'(s_axis_tdata[ID_W +: HANDLE_PW]);
  assign tin_ext = (TIME_WIDTH + TIME_PW)'(s_axis_tdata[ID_W + HANDLE_PW +: TIME_PW]);

  assign id_ext   = (IDX_W + ID_W)'(op_id);
  assign id_idx   = id_ext[IDX_W-1:0];
  assign id_found = (32'(op_id) < 32'(NUM_SLOTS)) && occ[id_idx];

  // shared compare unit of the scan walk
  assign due = (tick >= rd_next);

  assign tick_after = tick_inc ? tick + 1'b1 : tick;
  assign tout_ext   = (TIME_WIDTH + TIME_PW)'(tick_after);
  assign hout_ext   = (HANDLE_WIDTH + HANDLE_PW)'(e_handle);
  assign slot_ext   = (IDX_W + SLOT_PW)'(e_slot);

  pdt_slot_ram #(
    .NUM_SLOTS    (NUM_SLOTS),
    .TIME_WIDTH   (TIME_WIDTH),
    .HANDLE_WIDTH (HANDLE_WIDTH),
    .IDX_W        (IDX_W)
  ) u_ram (
    .clk       (clk),
    .we        (we),
    .wr_addr   (wr_addr),
    .wr_handle (op_handle),
    .wr_period (wr_period),
    .wr_next   (wr_next),
    .rd_addr   (idx),
    .rd_handle (rd_handle),
    .rd_period (rd_period),
    .rd_next   (rd_next)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            OP_ADD_PERIODIC, OP_ADD_AT: state_next = S_FIND;
            OP_SCAN:                    state_next = S_SCAN;
            default:                    state_next = S_EXEC;
          endcase
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_FIND: begin
        if ((!occ[idx] || at_last) && out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (occ[idx]) begin
          state_next = S_CMP;
        end else if (at_last) begin
          state_next = S_DONE;
        end
      end
      S_CMP: begin
        if (!(due && pend_valid && !out_free)) begin
          state_next = at_last ? S_DONE : S_SCAN;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    emit      = 1'b0;
    e_status  = ST_OK;
    e_slot    = '0;
    e_handle  = '0;
    e_last    = 1'b1;
    we        = '0;
    wr_addr   = idx;
    wr_period = op_time;
    wr_next   = '0;
    occ_wr    = 1'b0;
    occ_addr  = idx;
    occ_val   = 1'b0;
    tick_inc  = 1'b0;
    idx_inc   = 1'b0;
    pend_load = 1'b0;
    case (state)
      S_EXEC: begin
        if (out_free) begin
          emit = 1'b1;
          case (op)
            OP_DELETE: begin
              occ_addr = id_idx;
              if (id_found) begin
                occ_wr = 1'b1;
                e_slot = id_idx;
              end else begin
                e_status = ST_NOT_FOUND;
              end
            end
            OP_CHANGE: begin
              wr_addr = id_idx;
              if (id_found) begin
                we.period = 1'b1;
                e_slot    = id_idx;
              end else begin
                e_status = ST_NOT_FOUND;
              end
            end
            OP_TICK: tick_inc = 1'b1;
            default: ;
          endcase
        end
      end
      S_FIND: begin
        if (!occ[idx]) begin
          if (out_free) begin
            emit        = 1'b1;
            e_slot      = idx;
            we.handle   = 1'b1;
            we.period   = 1'b1;
            we.next_run = 1'b1;
            wr_period   = (op == OP_ADD_PERIODIC) ? op_time : '0;
            wr_next     = (op == OP_ADD_PERIODIC) ? '0 : op_time;
            // a zero handle leaves the slot free
            occ_wr      = 1'b1;
            occ_val     = (op_handle != '0);
          end
        end else if (at_last) begin
          if (out_free) begin
            emit     = 1'b1;
            e_status = ST_FULL;
          end
        end else begin
          idx_inc = 1'b1;
        end
      end
      S_SCAN: begin
        if (!occ[idx] && !at_last) begin
          idx_inc = 1'b1;
        end
      end
      S_CMP: begin
        if (!due) begin
          idx_inc = !at_last;
        end else if (!pend_valid || out_free) begin
          // previous dispatch goes out now that another one follows it
          emit        = pend_valid;
          e_status    = ST_DISPATCH;
          e_slot      = pend_slot;
          e_handle    = pend_handle;
          e_last      = 1'b0;
          we.next_run = 1'b1;
          wr_next     = tick + rd_period;
          pend_load   = 1'b1;
          idx_inc     = !at_last;
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit = 1'b1;
          if (pend_valid) begin
            e_status = ST_DISPATCH;
            e_slot   = pend_slot;
            e_handle = pend_handle;
          end else begin
            e_status = ST_NONE_DUE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tick       <= '0;
      occ        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      tick  <= tick_after;
      if (occ_wr) begin
        occ[occ_addr] <= occ_val;
      end
      if (accept) begin
        pend_valid <= 1'b0;
      end else if (pend_load) begin
        pend_valid <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx       <= '0;
      op        <= s_axis_tuser;
      op_id     <= s_axis_tdata[ID_W-1:0];
      op_handle <= hin_ext[HANDLE_WIDTH-1:0];
      op_time   <= tin_ext[TIME_WIDTH-1:0];
    end else if (idx_inc) begin
      idx <= idx + 1'b1;
    end
    if (pend_load) begin
      pend_slot   <= idx;
      pend_handle <= rd_handle;
    end
    if (emit) begin
      out_status <= e_status;
      out_slot   <= slot_ext[SLOT_PW-1:0];
      out_handle <= hout_ext[HANDLE_PW-1:0];
      out_time   <= tout_ext[TIME_PW-1:0];
      out_last   <= e_last;
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_time, out_handle, out_slot};
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

endmodule

### design/pdt_check.sv
module pdt_check import pdt_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [STATUS_W-1:0]   m_axis_tuser,
  input logic                  m_axis_tlast
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // one item at a time: busy right after an accept
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // only dispatch results may be followed by more results of the same item
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ST_DISPATCH) |-> m_axis_tlast)
    else $error("non-dispatch result without last");

  // dispatched tasks carry a handle, all other results a zero handle
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ((m_axis_tuser == ST_DISPATCH) == (m_axis_tdata[SLOT_PW +: HANDLE_PW] != '0)))
    else $error("handle does not match status");

  // status codes stay within the defined set
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_FULL ||
      m_axis_tuser == ST_NOT_FOUND || m_axis_tuser == ST_DISPATCH ||
      m_axis_tuser == ST_NONE_DUE))
    else $error("undefined status");

endmodule

bind periodic_task_dispatch_table pdt_check u_check (.*);

### tb/tb_periodic_task_dispatch_table.sv
module tb_periodic_task_dispatch_table import pdt_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = NUM_SLOTS_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 8;

  // opcodes the block answers without doing anything
  localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    status_t             status;
    logic [SLOT_PW-1:0]  slot;
    logic [HANDLE_PW-1:0] handle;
    logic [TIME_PW-1:0]  now;
    logic                last;
  } answer_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // task_id, task_handle, time_value, pad
  logic [OPCODE_W-1:0]   s_axis_tuser = '0;  // opcode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;       // slot, handle_out, time_now, pad
  logic [STATUS_W-1:0]   m_axis_tuser;       // status
  logic                  m_axis_tlast;

  // shadow copy of the task table
  logic [HANDLE_PW-1:0] tbl_handle [SLOTS];
  logic [TIME_PW-1:0]   tbl_period [SLOTS];
  logic [TIME_PW-1:0]   tbl_next_run [SLOTS];
  logic [TIME_PW-1:0]   tbl_ticks;

  answer_t pending_answers [$];
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      stall_left = 0;
  bit      sender_gaps = 1'b0;
  bit      sink_gaps = 1'b0;

  periodic_task_dispatch_table i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #6 clk = ~clk;

  function automatic void push_answer(status_t st, logic [SLOT_PW-1:0] sl,
                                      logic [HANDLE_PW-1:0] h, logic last);
    answer_t a;
    a.status = st;
    a.slot   = sl;
    a.handle = h;
    a.now    = tbl_ticks;
    a.last   = last;
    pending_answers.push_back(a);
  endfunction

  function automatic void apply_table_op(logic [OPCODE_W-1:0] op, logic [ID_W-1:0] id,
                                         logic [HANDLE_PW-1:0] h, logic [TIME_PW-1:0] tv);
    int s;
    int n;
    s = -1;
    n = 0;
    case (op)
      OP_ADD_PERIODIC, OP_ADD_AT: begin
        for (int i = SLOTS - 1; i >= 0; i--)
          if (tbl_handle[i] == '0) s = i;
        if (s < 0) begin
          push_answer(ST_FULL, '0, '0, 1'b1);
        end else begin
          // a zero handle still writes the slot, which then stays free
          tbl_handle[s]   = h;
          tbl_period[s]   = (op == OP_ADD_PERIODIC) ? tv : '0;
          tbl_next_run[s] = (op == OP_ADD_PERIODIC) ? '0 : tv;
          push_answer(ST_OK, s[SLOT_PW-1:0], '0, 1'b1);
        end
      end
      OP_DELETE, OP_CHANGE: begin
        if (tbl_handle[id] == '0) begin
          push_answer(ST_NOT_FOUND, '0, '0, 1'b1);
        end else begin
          if (op == OP_DELETE) begin
            tbl_handle[id]   = '0;
            tbl_period[id]   = '0;
            tbl_next_run[id] = '0;
          end else begin
            tbl_period[id] = tv;
          end
          push_answer(ST_OK, id, '0, 1'b1);
        end
      end
      OP_TICK: begin
        tbl_ticks = tbl_ticks + 1'b1;
        push_answer(ST_OK, '0, '0, 1'b1);
      end
      OP_SCAN: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_handle[i] != '0 && tbl_ticks >= tbl_next_run[i]) begin
            push_answer(ST_DISPATCH, i[SLOT_PW-1:0], tbl_handle[i], 1'b0);
            tbl_next_run[i] = tbl_ticks + tbl_period[i];
            n++;
          end
        end
        if (n == 0) push_answer(ST_NONE_DUE, '0, '0, 1'b1);
        else pending_answers[$].last = 1'b1;
      end
      default: push_answer(ST_OK, '0, '0, 1'b1);
    endcase
  endfunction

  function automatic int busy_slots();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++)
      if (tbl_handle[i] != '0) n++;
    return n;
  endfunction

  // random occupied slot when asked for one and there is one, any slot otherwise
  function automatic logic [ID_W-1:0] pick_slot(bit want_busy);
    int busy [$];
    for (int i = 0; i < SLOTS; i++)
      if (tbl_handle[i] != '0) busy.push_back(i);
    if (want_busy && busy.size() > 0)
      return ID_W'(busy[$urandom_range(0, busy.size() - 1)]);
    return ID_W'($urandom_range(0, SLOTS - 1));
  endfunction

  task automatic send_item(logic [OPCODE_W-1:0] op, logic [ID_W-1:0] id,
                           logic [HANDLE_PW-1:0] h, logic [TIME_PW-1:0] tv);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_DATA_W'({tv, h, id});
    do @(posedge clk); while (!s_axis_tready);
    apply_table_op(op, id, h, tv);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  task automatic test_directed();
    sender_gaps = 1'b1;
    sink_gaps  <= 1'b1;
    send_item(OP_SCAN, '0, '0, '0);                      // empty table, nothing due
    send_item(OP_TICK, '1, '1, '1);
    send_item(OP_SPARE_6, '1, '1, '1);
    send_item(OP_SPARE_7, '0, '0, '0);
    send_item(OP_DELETE, 4'd15, 16'h1234, '0);           // free slot
    send_item(OP_CHANGE, 4'd0, 16'h1234, 32'd5);         // free slot
    send_item(OP_ADD_PERIODIC, '0, 16'hFFFF, '0);
    send_item(OP_ADD_AT, '0, 16'h0001, 32'hFFFF_FFFF);   // never due
    send_item(OP_ADD_PERIODIC, '0, 16'h0000, 32'd9);     // zero handle leaves slot free
    send_item(OP_ADD_PERIODIC, '0, 16'h8000, 32'hFFFF_FFFF);  // next run wraps
    send_item(OP_SCAN, '0, '0, '0);
    send_item(OP_SCAN, '0, '0, '0);
    send_item(OP_CHANGE, 4'd0, 16'h5555, 32'd3);
    send_item(OP_TICK, '0, '0, '0);
    send_item(OP_SCAN, '0, '0, '0);
    send_item(OP_ADD_AT, '0, 16'h2AAA, 32'd3);
    send_item(OP_TICK, '0, '0, '0);
    send_item(OP_TICK, '0, '0, '0);
    send_item(OP_SCAN, '0, '0, '0);
    send_item(OP_DELETE, 4'd1, '0, '0);
    send_item(OP_DELETE, 4'd1, '0, '0);
    send_item(OP_CHANGE, 4'd2, 16'hAAAA, 32'h5555_5555);
    send_item(OP_SCAN, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_full_table();
    while (busy_slots() < SLOTS)
      send_item(OP_ADD_PERIODIC, '0, HANDLE_PW'($urandom_range(1, 16'hFFFF)),
                $urandom_range(0, 3));
    send_item(OP_ADD_PERIODIC, '0, 16'h4321, 32'd1);
    send_item(OP_ADD_AT, '0, 16'h4322, 32'd1);
    // scan of the full table; the slots just added are all due
    send_item(OP_SCAN, '0, '0, '0);
    wait_drained();
    repeat (SLOTS / 2) send_item(OP_DELETE, pick_slot(1'b1), '0, '0);
  endtask

  task automatic test_random(int count);
    int kind;
    logic [HANDLE_PW-1:0] h;
    logic [TIME_PW-1:0] tv;
    for (int n = 0; n < count; n++) begin
      if (n % 30 == 0) begin
        sender_gaps = (n < count - 40) && ($urandom_range(0, 2) != 0);
        sink_gaps  <= (n < count - 40) && ($urandom_range(0, 2) != 0);
      end
      if (n == count / 2) wait_drained();
      h = HANDLE_PW'($urandom_range(1, 16'hFFFF));
      if ($urandom_range(0, 30) == 0) h = '0;
      kind = $urandom_range(0, 99);
      if (kind < 14) begin
        tv = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 6);
        send_item(OP_ADD_PERIODIC, ID_W'($urandom_range(0, 15)), h, tv);
      end else if (kind < 22) begin
        tv = ($urandom_range(0, 7) == 0) ? $urandom : tbl_ticks + $urandom_range(0, 8);
        send_item(OP_ADD_AT, ID_W'($urandom_range(0, 15)), h, tv);
      end else if (kind < 40) begin
        send_item(OP_DELETE, pick_slot($urandom_range(0, 9) != 0), HANDLE_PW'($urandom),
                  $urandom);
      end else if (kind < 48) begin
        tv = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 6);
        send_item(OP_CHANGE, pick_slot($urandom_range(0, 9) != 0), HANDLE_PW'($urandom), tv);
      end else if (kind < 72) begin
        send_item(OP_TICK, ID_W'($urandom), HANDLE_PW'($urandom), $urandom);
      end else if (kind < 95) begin
        send_item(OP_SCAN, ID_W'($urandom), HANDLE_PW'($urandom), $urandom);
      end else begin
        send_item($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7, ID_W'($urandom),
                  HANDLE_PW'($urandom), $urandom);
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 1) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
      stall_left    <= $urandom_range(1, 7);
      m_axis_tready <= 1'b0;
    end else begin
      stall_left    <= 0;
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    answer_t want;
    answer_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = status_t'(m_axis_tuser);
      got.slot   = m_axis_tdata[SLOT_PW-1:0];
      got.handle = m_axis_tdata[SLOT_PW +: HANDLE_PW];
      got.now    = m_axis_tdata[SLOT_PW + HANDLE_PW +: TIME_PW];
      got.last   = m_axis_tlast;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result status=%0d slot=%0d handle=%h now=%0d last=%b",
                   $realtime, got.status, got.slot, got.handle, got.now, got.last);
      end else begin
        want = pending_answers.pop_front();
        if (got.status !== want.status || got.slot !== want.slot ||
            got.handle !== want.handle || got.now !== want.now || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected status=%0d slot=%0d handle=%h now=%0d last=%b",
                     $realtime, want.status, want.slot, want.handle, want.now, want.last,
                     ", got status=%0d slot=%0d handle=%h now=%0d last=%b",
                     got.status, got.slot, got.handle, got.now, got.last);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_periodic_task_dispatch_table NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_handle[i]   = '0;
      tbl_period[i]   = '0;
      tbl_next_run[i] = '0;
    end
    tbl_ticks = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random(210);
    sender_gaps = 1'b0;
    sink_gaps  <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("tb_periodic_task_dispatch_table OK");
    end else begin
      $display("tb_periodic_task_dispatch_table NOT OK");
    end
    $finish;
  end

endmodule
